// ----- src/masr_pkg.sv -----
// Shared types, constants and the control program of the alarm scheduler/ringer.
// Depends on nothing; masr_seq and the top level refer to it by scoped names.
package masr_pkg;

   // Sizes and limits
   localparam int ALARM_SLOTS_DEFAULT = 8;
   localparam int SLOT_SPACE          = 8;      // reachable through the 3-bit slot field
   localparam logic [4:0]  MAX_HOUR   = 5'd23;
   localparam logic [5:0]  MAX_MINUTE = 6'd59;
   localparam logic [10:0] MIN_PER_DAY = 11'd1440;
   localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

   // Request actions
   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_MATCH   = 2'd1,
      ACT_DISMISS = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   // One table entry as stored in the RAM
   typedef struct packed {
      logic       enable;
      logic [4:0] hour;
      logic [5:0] minute;
   } alarm_entry_type;

   localparam int ENTRY_W = $bits(alarm_entry_type);

   // Datapath operations, one per control word
   typedef enum logic [2:0] {
      OP_WAIT,
      OP_EXEC,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_FINISH,
      OP_RESPOND
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NO_RESCHED,
      COND_NOT_LAST,
      COND_OUT_BUSY
   } cond_type;

   // Program steps
   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_EXEC,
      STEP_SCAN_START,
      STEP_SCAN,
      STEP_FINISH,
      STEP_RESPOND
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_to;   // taken when cond holds
      step_type next_to;   // taken otherwise
   } ctrl_word_type;

   // Status from the datapath that the sequencer branches on
   typedef struct packed {
      logic no_req;
      logic no_resched;
      logic not_last;
      logic out_busy;
   } cond_flags_type;

   // Control store
   function automatic ctrl_word_type program_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         STEP_WAIT:       w = '{OP_WAIT,       COND_NO_REQ,     STEP_WAIT,    STEP_EXEC};
         STEP_EXEC:       w = '{OP_EXEC,       COND_NO_RESCHED, STEP_FINISH,  STEP_SCAN_START};
         STEP_SCAN_START: w = '{OP_SCAN_START, COND_ALWAYS,     STEP_SCAN,    STEP_SCAN};
         STEP_SCAN:       w = '{OP_SCAN_STEP,  COND_NOT_LAST,   STEP_SCAN,    STEP_FINISH};
         STEP_FINISH:     w = '{OP_FINISH,     COND_ALWAYS,     STEP_RESPOND, STEP_RESPOND};
         STEP_RESPOND:    w = '{OP_RESPOND,    COND_OUT_BUSY,   STEP_RESPOND, STEP_WAIT};
         default:         w = '{OP_WAIT,       COND_ALWAYS,     STEP_WAIT,    STEP_WAIT};
      endcase
      return w;
   endfunction

   // Minute of day from hour and minute: h*60 + m
   function automatic logic [10:0] minute_of_day(input logic [4:0] h, input logic [5:0] m);
      logic [10:0] hw;
      hw = {6'b0, h};
      return (hw << 6) - (hw << 2) + {5'b0, m};
   endfunction

endpackage

// ----- src/masr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module masr_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/masr_seq.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jump.
// Depends on masr_pkg (program_rom, control word and flag types).
module masr_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  masr_pkg::cond_flags_type flags,
   output masr_pkg::op_type        op
);

   masr_pkg::step_type      step_ff, step_in;
   masr_pkg::ctrl_word_type word;
   logic                    take;

   assign word = masr_pkg::program_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         masr_pkg::COND_ALWAYS:     take = 1'b1;
         masr_pkg::COND_NO_REQ:     take = flags.no_req;
         masr_pkg::COND_NO_RESCHED: take = flags.no_resched;
         masr_pkg::COND_NOT_LAST:   take = flags.not_last;
         masr_pkg::COND_OUT_BUSY:   take = flags.out_busy;
         default:                   take = 1'b1;
      endcase
   end

   always_comb begin
      step_in = take ? word.jump_to : word.next_to;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= masr_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign op = word.op;

endmodule

// ----- src/multi_alarm_scheduler_ringer_core.sv -----
// Multi-alarm scheduler and ringer, top level.
// A word that needs no reschedule runs the execute, finish and respond steps after acceptance;
//   one that reschedules also scans every table slot between execute and finish.
// A new word is accepted only in the wait step, after the last one has responded; the rescan reads
//   one slot per cycle from the single read port of the alarm table RAM. Synchronous active-high
//   reset clears all control state, the valid bits of the table and sets the timeout to 60000 ms.
// Depends on masr_pkg, masr_seq and masr_ram.
module multi_alarm_scheduler_ringer_core #(
   parameter int ALARM_SLOTS = masr_pkg::ALARM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_slot,
   input  logic [4:0]  req_new_hour,
   input  logic [5:0]  req_new_minute,
   input  logic        req_new_enable,
   input  logic [4:0]  req_now_hour,
   input  logic [5:0]  req_now_minute,
   input  logic [31:0] req_now_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_armed,
   output logic [2:0]  rsp_armed_slot,
   output logic [4:0]  rsp_armed_hour,
   output logic [5:0]  rsp_armed_minute,
   output logic        rsp_is_ringing,
   output logic [2:0]  rsp_ringing_slot,
   output logic        rsp_buzzer_start,
   output logic        rsp_buzzer_halt,
   output logic [4:0]  rsp_read_hour,
   output logic [5:0]  rsp_read_minute,
   output logic        rsp_read_enable,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_ring_timeout_ms
);

   // Only slots reachable through the 3-bit slot field are stored; others stay disabled.
   localparam int TableDepth = (ALARM_SLOTS < masr_pkg::SLOT_SPACE) ?
                               ALARM_SLOTS : masr_pkg::SLOT_SPACE;
   localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   masr_pkg::op_type         op;
   masr_pkg::cond_flags_type flags;

   masr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   // captured request word
   masr_pkg::action_type act_ff,  act_in;
   logic [2:0]   slot_ff,     slot_in;
   logic [4:0]   nh_ff,       nh_in;
   logic [5:0]   nm_ff,       nm_in;
   logic         ne_ff,       ne_in;
   logic [4:0]   now_h_ff,    now_h_in;
   logic [5:0]   now_m_ff,    now_m_in;
   logic [31:0]  now_ms_ff,   now_ms_in;

   // block state
   logic [TableDepth-1:0] valid_ff, valid_in;
   logic         ringing_ff,   ringing_in;
   logic [2:0]   ring_slot_ff, ring_slot_in;
   logic [31:0]  ring_start_ff, ring_start_in;
   logic         armed_ff,     armed_in;
   logic [2:0]   sched_ff,     sched_in;
   logic [4:0]   arm_hour_ff,  arm_hour_in;
   logic [5:0]   arm_min_ff,   arm_min_in;
   logic [31:0]  timeout_ff,   timeout_in;

   // per-word working registers
   logic         resched_ff,   resched_in;
   logic         start_ff,     start_in;
   logic         stop_ff,      stop_in;
   logic [10:0]  now_min_ff,   now_min_in;
   logic [IdxW-1:0] eval_idx_ff, eval_idx_in;
   logic         found_ff,     found_in;
   logic [10:0]  best_dist_ff, best_dist_in;
   logic [2:0]   best_slot_ff, best_slot_in;
   logic [4:0]   best_hour_ff, best_hour_in;
   logic [5:0]   best_min_ff,  best_min_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic         o_armed_ff,   o_armed_in;
   logic [2:0]   o_aslot_ff,   o_aslot_in;
   logic [4:0]   o_ahour_ff,   o_ahour_in;
   logic [5:0]   o_amin_ff,    o_amin_in;
   logic         o_ring_ff,    o_ring_in;
   logic [2:0]   o_rslot_ff,   o_rslot_in;
   logic         o_start_ff,   o_start_in;
   logic         o_stop_ff,    o_stop_in;
   logic [4:0]   o_rhour_ff,   o_rhour_in;
   logic [5:0]   o_rmin_ff,    o_rmin_in;
   logic         o_ren_ff,     o_ren_in;

   // ---------------------------------------------------------------
   // Alarm table RAM
   // ---------------------------------------------------------------
   logic [IdxW-1:0]          slot_idx;
   logic                     ram_we;
   logic [IdxW-1:0]          ram_raddr;
   masr_pkg::alarm_entry_type ram_wdata;
   logic [masr_pkg::ENTRY_W-1:0] ram_rdata;
   masr_pkg::alarm_entry_type ent;

   masr_ram #(
      .WIDTH (masr_pkg::ENTRY_W),
      .DEPTH (TableDepth),
      .AW    (IdxW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_idx),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ent = masr_pkg::alarm_entry_type'(ram_rdata);

   // ---------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------
   logic            slot_ok;
   logic            out_busy;
   logic            req_fire;
   logic            resched_now;
   logic            tick_expired;
   logic            is_last;
   logic            ent_ok;
   logic [10:0]     ent_min;
   logic [10:0]     ent_dist;
   logic [4:0]      clamp_h;
   logic [5:0]      clamp_m;

   assign slot_idx  = slot_ff[IdxW-1:0];
   assign slot_ok   = ({29'b0, slot_ff} < 32'(ALARM_SLOTS));
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign req_ready = (op == masr_pkg::OP_WAIT);
   assign csr_ready = 1'b1;

   // wrapping difference against the configured timeout
   assign tick_expired = ringing_ff && ((now_ms_ff - ring_start_ff) >= timeout_ff);
   assign is_last      = (eval_idx_ff == IdxW'(TableDepth - 1));

   // a reschedule follows an in-range write, any dismiss and an expired tick
   always_comb begin
      case (act_ff)
         masr_pkg::ACT_WRITE:   resched_now = slot_ok;
         masr_pkg::ACT_DISMISS: resched_now = 1'b1;
         masr_pkg::ACT_TICK:    resched_now = tick_expired;
         default:               resched_now = 1'b0;
      endcase
   end

   assign flags = '{no_req:     !req_valid,
                    no_resched: !resched_now,
                    not_last:   !is_last,
                    out_busy:   out_busy};

   // candidate evaluation: skip never-written and disabled slots and the one now ringing
   assign ent_ok  = valid_ff[eval_idx_ff] && ent.enable &&
                    !(ringing_ff && (ring_slot_ff == 3'(eval_idx_ff)));
   assign ent_min = masr_pkg::minute_of_day(ent.hour, ent.minute);
   // distance of 0 or less wraps by a full day
   assign ent_dist = (ent_min > now_min_ff) ? (ent_min - now_min_ff)
                                            : (ent_min + masr_pkg::MIN_PER_DAY - now_min_ff);

   assign clamp_h = (now_h_ff > masr_pkg::MAX_HOUR)   ? masr_pkg::MAX_HOUR   : now_h_ff;
   assign clamp_m = (now_m_ff > masr_pkg::MAX_MINUTE) ? masr_pkg::MAX_MINUTE : now_m_ff;

   // table write data, clamped
   assign ram_wdata = '{enable: ne_ff,
                        hour:   (nh_ff > masr_pkg::MAX_HOUR)   ? masr_pkg::MAX_HOUR   : nh_ff,
                        minute: (nm_ff > masr_pkg::MAX_MINUTE) ? masr_pkg::MAX_MINUTE : nm_ff};

   // ---------------------------------------------------------------
   // Control word decode: next values of all registers
   // ---------------------------------------------------------------
   always_comb begin
      // hold by default
      act_in        = act_ff;
      slot_in       = slot_ff;
      nh_in         = nh_ff;
      nm_in         = nm_ff;
      ne_in         = ne_ff;
      now_h_in      = now_h_ff;
      now_m_in      = now_m_ff;
      now_ms_in     = now_ms_ff;
      valid_in      = valid_ff;
      ringing_in    = ringing_ff;
      ring_slot_in  = ring_slot_ff;
      ring_start_in = ring_start_ff;
      armed_in      = armed_ff;
      sched_in      = sched_ff;
      arm_hour_in   = arm_hour_ff;
      arm_min_in    = arm_min_ff;
      resched_in    = resched_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      now_min_in    = now_min_ff;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      best_dist_in  = best_dist_ff;
      best_slot_in  = best_slot_ff;
      best_hour_in  = best_hour_ff;
      best_min_in   = best_min_ff;
      o_armed_in    = o_armed_ff;
      o_aslot_in    = o_aslot_ff;
      o_ahour_in    = o_ahour_ff;
      o_amin_in     = o_amin_ff;
      o_ring_in     = o_ring_ff;
      o_rslot_in    = o_rslot_ff;
      o_start_in    = o_start_ff;
      o_stop_in     = o_stop_ff;
      o_rhour_in    = o_rhour_ff;
      o_rmin_in     = o_rmin_ff;
      o_ren_in      = o_ren_ff;
      ram_we        = 1'b0;
      ram_raddr     = slot_idx;   // readback address unless the scan owns the port

      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // configuration write
      timeout_in = (csr_valid && csr_ready) ? csr_ring_timeout_ms : timeout_ff;

      unique case (op)
         masr_pkg::OP_WAIT: begin
            if (req_fire) begin
               act_in    = masr_pkg::action_type'(req_action);
               slot_in   = req_slot;
               nh_in     = req_new_hour;
               nm_in     = req_new_minute;
               ne_in     = req_new_enable;
               now_h_in  = req_now_hour;
               now_m_in  = req_now_minute;
               now_ms_in = req_now_ms;
            end
         end

         masr_pkg::OP_EXEC: begin
            resched_in = resched_now;
            start_in   = 1'b0;
            stop_in    = 1'b0;
            now_min_in = masr_pkg::minute_of_day(clamp_h, clamp_m);
            case (act_ff)
               masr_pkg::ACT_WRITE: begin
                  if (slot_ok) begin
                     ram_we             = 1'b1;
                     valid_in[slot_idx] = 1'b1;
                  end
               end
               masr_pkg::ACT_MATCH: begin
                  // ignore a match while disarmed
                  if (armed_ff) begin
                     ringing_in    = 1'b1;
                     ring_slot_in  = sched_ff;
                     ring_start_in = now_ms_ff;
                     start_in      = 1'b1;
                  end
               end
               masr_pkg::ACT_DISMISS: begin
                  ringing_in = 1'b0;
                  stop_in    = 1'b1;
               end
               default: begin
                  if (tick_expired) begin
                     ringing_in = 1'b0;
                     stop_in    = 1'b1;
                  end
               end
            endcase
         end

         masr_pkg::OP_SCAN_START: begin
            ram_raddr   = '0;
            eval_idx_in = '0;
            found_in    = 1'b0;
         end

         masr_pkg::OP_SCAN_STEP: begin
            // evaluate the slot read last cycle, fetch the next one
            ram_raddr   = eval_idx_ff + IdxW'(1);
            eval_idx_in = eval_idx_ff + IdxW'(1);
            if (ent_ok && (!found_ff || (ent_dist < best_dist_ff))) begin
               found_in     = 1'b1;
               best_dist_in = ent_dist;
               best_slot_in = 3'(eval_idx_ff);
               best_hour_in = ent.hour;
               best_min_in  = ent.minute;
            end
         end

         masr_pkg::OP_FINISH: begin
            if (resched_ff) begin
               armed_in    = found_ff;
               sched_in    = found_ff ? best_slot_ff : 3'd0;
               arm_hour_in = found_ff ? best_hour_ff : 5'd0;
               arm_min_in  = found_ff ? best_min_ff  : 6'd0;
            end
         end

         masr_pkg::OP_RESPOND: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               o_armed_in   = armed_ff;
               o_aslot_in   = sched_ff;
               o_ahour_in   = arm_hour_ff;
               o_amin_in    = arm_min_ff;
               o_ring_in    = ringing_ff;
               o_rslot_in   = ring_slot_ff;
               o_start_in   = start_ff;
               o_stop_in    = stop_ff;
               // a slot never written reads as zero
               if (slot_ok && valid_ff[slot_idx]) begin
                  o_rhour_in = ent.hour;
                  o_rmin_in  = ent.minute;
                  o_ren_in   = ent.enable;
               end else begin
                  o_rhour_in = 5'd0;
                  o_rmin_in  = 6'd0;
                  o_ren_in   = 1'b0;
               end
            end
         end

         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         ringing_ff    <= 1'b0;
         ring_slot_ff  <= 3'd0;
         ring_start_ff <= 32'd0;
         armed_ff      <= 1'b0;
         sched_ff      <= 3'd0;
         arm_hour_ff   <= 5'd0;
         arm_min_ff    <= 6'd0;
         timeout_ff    <= masr_pkg::TIMEOUT_RESET;
         resched_ff    <= 1'b0;
         start_ff      <= 1'b0;
         stop_ff       <= 1'b0;
         found_ff      <= 1'b0;
         eval_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         ringing_ff    <= ringing_in;
         ring_slot_ff  <= ring_slot_in;
         ring_start_ff <= ring_start_in;
         armed_ff      <= armed_in;
         sched_ff      <= sched_in;
         arm_hour_ff   <= arm_hour_in;
         arm_min_ff    <= arm_min_in;
         timeout_ff    <= timeout_in;
         resched_ff    <= resched_in;
         start_ff      <= start_in;
         stop_ff       <= stop_in;
         found_ff      <= found_in;
         eval_idx_ff   <= eval_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      slot_ff      <= slot_in;
      nh_ff        <= nh_in;
      nm_ff        <= nm_in;
      ne_ff        <= ne_in;
      now_h_ff     <= now_h_in;
      now_m_ff     <= now_m_in;
      now_ms_ff    <= now_ms_in;
      now_min_ff   <= now_min_in;
      best_dist_ff <= best_dist_in;
      best_slot_ff <= best_slot_in;
      best_hour_ff <= best_hour_in;
      best_min_ff  <= best_min_in;
      o_armed_ff   <= o_armed_in;
      o_aslot_ff   <= o_aslot_in;
      o_ahour_ff   <= o_ahour_in;
      o_amin_ff    <= o_amin_in;
      o_ring_ff    <= o_ring_in;
      o_rslot_ff   <= o_rslot_in;
      o_start_ff   <= o_start_in;
      o_stop_ff    <= o_stop_in;
      o_rhour_ff   <= o_rhour_in;
      o_rmin_ff    <= o_rmin_in;
      o_ren_ff     <= o_ren_in;
   end

   // ---------------------------------------------------------------
   // Response ports
   // ---------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_armed        = o_armed_ff;
   assign rsp_armed_slot   = o_aslot_ff;
   assign rsp_armed_hour   = o_ahour_ff;
   assign rsp_armed_minute = o_amin_ff;
   assign rsp_is_ringing   = o_ring_ff;
   assign rsp_ringing_slot = o_rslot_ff;
   assign rsp_buzzer_start = o_start_ff;
   assign rsp_buzzer_halt  = o_stop_ff;
   assign rsp_read_hour    = o_rhour_ff;
   assign rsp_read_minute  = o_rmin_ff;
   assign rsp_read_enable  = o_ren_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_accept_runs_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (op == masr_pkg::OP_EXEC))
      else $error("accepted word did not enter the execute step");

   a_disarmed_slot_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (sched_ff == 3'd0))
      else $error("scheduled slot nonzero while disarmed");

   a_start_implies_ring: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_buzzer_start) |-> (rsp_is_ringing && rsp_armed))
      else $error("buzzer start without ringing on an armed slot");

   a_start_stop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_buzzer_start && rsp_buzzer_halt))
      else $error("buzzer start and stop in the same word");

endmodule
